### hdl/sfva_pkg.sv
// Shared types and constants of the sound effect voice arbiter.
package sfva_pkg;

  // Command codes of an input item
  typedef enum logic [1:0] {
    CmdTick      = 2'd0,
    CmdShot      = 2'd1,
    CmdEffect    = 2'd2,
    CmdSetActive = 2'd3
  } cmd_e;

  // Fixed volume of the shot voice
  localparam logic [6:0] ShotVolume = 7'd60;

  // Input item
  typedef struct packed {
    cmd_e        cmd;
    logic [3:0]  effect;
    logic [3:0]  priority_req;
    logic [7:0]  cooldown_ticks;
    logic [7:0]  duration_ticks;
    logic [6:0]  volume;
    logic        sample_loaded;
    logic        active;
  } item_t;

  // Result item
  typedef struct packed {
    logic        start_shot_voice;
    logic        start_effect_voice;
    logic [6:0]  start_volume;
    logic        stop_shot_voice;
    logic        stop_effect_voice;
  } result_t;

endpackage

### hdl/sfva_if.sv
// Valid/ready channel interfaces for input items and result items.
interface sfva_in_if import sfva_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sfva_out_if import sfva_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/sfva_core.sv
// Voice and cooldown state with the arbitration logic for one item.
module sfva_core import sfva_pkg::*; #(
  parameter int NUM_EFFECTS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  item_t   item_i,
  output result_t res_o
);

  localparam int IdxW = (NUM_EFFECTS > 1) ? $clog2(NUM_EFFECTS) : 1;

  logic                 active_q, active_d;
  logic [7:0]           shot_ticks_q, shot_ticks_d;
  logic [7:0]           eff_ticks_q, eff_ticks_d;
  logic [3:0]           prio_q, prio_d;
  logic [7:0]           cool_q [NUM_EFFECTS];
  logic [7:0]           cool_d [NUM_EFFECTS];

  logic                 in_range;
  logic [IdxW-1:0]      eff_idx;
  logic [7:0]           cool_sel;
  logic                 blocked;

  // Select the requested effect's cooldown
  assign in_range = 32'(item_i.effect) < NUM_EFFECTS;
  assign eff_idx  = IdxW'(item_i.effect);
  assign cool_sel = in_range ? cool_q[eff_idx] : 8'd0;
  assign blocked  = (eff_ticks_q != 8'd0) && (prio_q > item_i.priority_req);

  // Decide the result and the next state
  always_comb begin
    res_o        = '0;
    active_d     = active_q;
    shot_ticks_d = shot_ticks_q;
    eff_ticks_d  = eff_ticks_q;
    prio_d       = prio_q;
    for (int i = 0; i < NUM_EFFECTS; i++) begin
      cool_d[i] = cool_q[i];
    end
    case (item_i.cmd)
      CmdTick: begin
        if (active_q && shot_ticks_q != 8'd0) begin
          shot_ticks_d = shot_ticks_q - 8'd1;
          res_o.stop_shot_voice = (shot_ticks_q == 8'd1);
        end
        if (active_q && eff_ticks_q != 8'd0) begin
          eff_ticks_d = eff_ticks_q - 8'd1;
          if (eff_ticks_q == 8'd1) begin
            res_o.stop_effect_voice = 1'b1;
            prio_d = 4'd0;
          end
        end
        for (int i = 0; i < NUM_EFFECTS; i++) begin
          if (cool_q[i] != 8'd0) cool_d[i] = cool_q[i] - 8'd1;
        end
      end
      CmdShot: begin
        if (item_i.sample_loaded && active_q) begin
          res_o.start_shot_voice = 1'b1;
          res_o.start_volume     = ShotVolume;
          shot_ticks_d           = item_i.duration_ticks;
        end
      end
      CmdEffect: begin
        if (item_i.sample_loaded && active_q && in_range && cool_sel == 8'd0 && !blocked) begin
          res_o.start_effect_voice = 1'b1;
          res_o.start_volume       = item_i.volume;
          eff_ticks_d              = item_i.duration_ticks;
          prio_d                   = item_i.priority_req;
          cool_d[eff_idx]          = item_i.cooldown_ticks;
        end
      end
      CmdSetActive: begin
        active_d = item_i.active;
        if (!item_i.active) begin
          res_o.stop_shot_voice   = 1'b1;
          res_o.stop_effect_voice = 1'b1;
          shot_ticks_d = 8'd0;
          eff_ticks_d  = 8'd0;
          prio_d       = 4'd0;
          for (int i = 0; i < NUM_EFFECTS; i++) begin
            cool_d[i] = 8'd0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Update the state when an item advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      shot_ticks_q <= 8'd0;
      eff_ticks_q  <= 8'd0;
      prio_q       <= 4'd0;
      for (int i = 0; i < NUM_EFFECTS; i++) begin
        cool_q[i] <= 8'd0;
      end
    end else if (en_i) begin
      active_q     <= active_d;
      shot_ticks_q <= shot_ticks_d;
      eff_ticks_q  <= eff_ticks_d;
      prio_q       <= prio_d;
      for (int i = 0; i < NUM_EFFECTS; i++) begin
        cool_q[i] <= cool_d[i];
      end
    end
  end

  // The two voices never start from one item
  a_one_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_o.start_shot_voice && res_o.start_effect_voice))
    else $error("both voices started by one item");

  // A started shot plays at the fixed shot volume
  a_shot_volume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.start_shot_voice |-> res_o.start_volume == ShotVolume)
    else $error("shot started at wrong volume");

  // A granted effect loads its duration and priority
  a_effect_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && res_o.start_effect_voice |=>
      eff_ticks_q == $past(item_i.duration_ticks) && prio_q == $past(item_i.priority_req))
    else $error("granted effect did not load its voice state");

  // Deactivation clears the voices and the flag
  a_deactivate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && item_i.cmd == CmdSetActive && !item_i.active |=>
      !active_q && shot_ticks_q == 8'd0 && eff_ticks_q == 8'd0 && prio_q == 4'd0)
    else $error("deactivation left voice state behind");

endmodule

### hdl/sound_effect_voice_arbiter.sv
// Top level of the sound effect voice arbiter: input and result registers around the core.
//
// Use: items enter on in_i (valid/ready) and each gives exactly one result
// item on out_o. An item is a tick, a shot request, an effect request
// or a write of the active flag. The result says which voice to start (and
// at what volume) and which voices to stop.
// Path: an accepted item passes through the input register and then the
// result register on its way to out_o.
// Throughput: one item per cycle while out_o is ready; the arbitration and
// the counter updates sit in one short stage between the two registers.
// Stall: when out_o is not ready the result register holds, the input
// register keeps one more item and in_i stays ready until both are full.
// Reset: both registers empty, the block inactive, voice counters, the
// recorded priority and all NUM_EFFECTS cooldowns cleared at once.
module sound_effect_voice_arbiter import sfva_pkg::*; #(
  parameter int NUM_EFFECTS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  sfva_in_if.sink    in_i,
  sfva_out_if.source out_o
);

  logic    in_valid_q;
  item_t   in_q;
  logic    out_valid_q;
  result_t out_q;
  result_t res;
  logic    advance;

  // Move the held item into the result register when it is free
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) in_q <= in_i.data;
  end

  sfva_core #(
    .NUM_EFFECTS(NUM_EFFECTS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (in_q),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_q <= res;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

### tb/sv/tb_top.sv
// Testbench top of the sound effect voice arbiter: stimulus, prediction and result checking.
`timescale 1ns / 100ps

module tb_top;
  import sfva_pkg::*;

  localparam int NumEffects = 16;

  logic clk_i;
  logic rst_ni;

  sfva_in_if  in_if ();
  sfva_out_if out_if ();

  sound_effect_voice_arbiter #(
    .NUM_EFFECTS(NumEffects)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Predicted arbiter state
  logic       arb_active;
  logic [7:0] shot_left;
  logic [7:0] effect_left;
  logic [3:0] held_priority;
  logic [7:0] cooldown [NumEffects];

  result_t     pending_results [$];
  int unsigned mismatches;
  bit          gaps_on;
  int unsigned rx_hold_cycles;

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Clear both voice counters, the held priority and every cooldown
  function automatic void clear_counters();
    shot_left     = '0;
    effect_left   = '0;
    held_priority = '0;
    foreach (cooldown[i]) cooldown[i] = '0;
  endfunction

  // Work out the result of one item and advance the predicted state
  function automatic result_t arbitrate(item_t it);
    result_t r;
    r = '0;
    case (it.cmd)
      CmdTick: begin
        if (arb_active && shot_left != 0) begin
          shot_left = shot_left - 8'd1;
          if (shot_left == 0) r.stop_shot_voice = 1'b1;
        end
        if (arb_active && effect_left != 0) begin
          effect_left = effect_left - 8'd1;
          if (effect_left == 0) begin
            r.stop_effect_voice = 1'b1;
            held_priority       = '0;
          end
        end
        // cooldowns run even while inactive
        foreach (cooldown[i]) if (cooldown[i] != 0) cooldown[i] = cooldown[i] - 8'd1;
      end
      CmdShot: begin
        if (it.sample_loaded && arb_active) begin
          r.start_shot_voice = 1'b1;
          r.start_volume     = ShotVolume;
          shot_left          = it.duration_ticks;
        end
      end
      CmdEffect: begin
        // drop when inactive, missing, out of range, cooling down or outranked
        if (it.sample_loaded && arb_active && int'(it.effect) < NumEffects) begin
          if (cooldown[it.effect] == 0 &&
              !(effect_left != 0 && held_priority > it.priority_req)) begin
            r.start_effect_voice = 1'b1;
            r.start_volume       = it.volume;
            effect_left          = it.duration_ticks;
            held_priority        = it.priority_req;
            cooldown[it.effect]  = it.cooldown_ticks;
          end
        end
      end
      CmdSetActive: begin
        arb_active = it.active;
        if (!it.active) begin
          r.stop_shot_voice   = 1'b1;
          r.stop_effect_voice = 1'b1;
          clear_counters();
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic item_t make_item(cmd_e cmd, int effect, int prio, int cool, int dur,
                                      int vol, bit loaded, bit act);
    item_t it;
    it.cmd            = cmd;
    it.effect         = 4'(effect);
    it.priority_req   = 4'(prio);
    it.cooldown_ticks = 8'(cool);
    it.duration_ticks = 8'(dur);
    it.volume         = 7'(vol);
    it.sample_loaded  = loaded;
    it.active         = act;
    return it;
  endfunction

  // Draw one item: mostly plausible traffic, noise when asked
  function automatic item_t random_item(bit noise);
    item_t       it;
    int unsigned pick;
    it.effect         = 4'($urandom_range(0, 15));
    it.priority_req   = 4'($urandom_range(0, 15));
    it.volume         = 7'($urandom_range(0, 127));
    it.active         = 1'($urandom_range(0, 1));
    if (noise) begin
      it.cmd            = cmd_e'($urandom_range(0, 3));
      it.cooldown_ticks = 8'($urandom_range(0, 255));
      it.duration_ticks = 8'($urandom_range(0, 255));
      it.sample_loaded  = 1'($urandom_range(0, 1));
      return it;
    end
    // short counts so voices expire and effects come back often
    it.duration_ticks = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(0, 6));
    it.cooldown_ticks = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(0, 4));
    it.sample_loaded  = ($urandom_range(0, 9) != 0);
    pick = $urandom_range(0, 99);
    if (!arb_active && pick < 50) begin
      it.cmd    = CmdSetActive;
      it.active = 1'b1;
    end else if (pick < 40) begin
      it.cmd = CmdTick;
    end else if (pick < 55) begin
      it.cmd = CmdShot;
    end else if (pick < 95) begin
      it.cmd = CmdEffect;
    end else begin
      it.cmd    = CmdSetActive;
      it.active = ($urandom_range(0, 3) != 0);
    end
    return it;
  endfunction

  // Offer one item after a random gap (when gaps are on) and predict its result on acceptance
  task automatic send_item(item_t it);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(arbitrate(it));
  endtask

  // Drop valid and hold until every predicted result has arrived
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Field extremes, every command and each corner of the arbitration
  task automatic test_directed();
    send_item(make_item(CmdTick, 0, 0, 0, 0, 0, 1'b1, 1'b0));
    send_item(make_item(CmdShot, 0, 0, 0, 3, 10, 1'b1, 1'b0));
    send_item(make_item(CmdEffect, 0, 7, 2, 3, 20, 1'b1, 1'b0));
    // deactivate with nothing playing
    send_item(make_item(CmdSetActive, 0, 0, 0, 0, 0, 1'b1, 1'b0));
    send_item(make_item(CmdSetActive, 0, 0, 0, 0, 0, 1'b1, 1'b1));
    send_item(make_item(CmdSetActive, 15, 15, 255, 255, 127, 1'b0, 1'b1));
    send_item(make_item(CmdShot, 0, 0, 0, 3, 10, 1'b0, 1'b0));
    // shot ignores effect, priority, cooldown and volume
    send_item(make_item(CmdShot, 15, 15, 255, 2, 127, 1'b1, 1'b0));
    send_item(make_item(CmdTick, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    send_item(make_item(CmdTick, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    // zero-length shot never stops on a tick
    send_item(make_item(CmdShot, 0, 0, 0, 0, 0, 1'b1, 1'b0));
    send_item(make_item(CmdEffect, 0, 5, 3, 2, 64, 1'b1, 1'b0));
    send_item(make_item(CmdEffect, 1, 4, 0, 2, 30, 1'b1, 1'b0));
    // equal priority takes over
    send_item(make_item(CmdEffect, 2, 5, 1, 2, 0, 1'b1, 1'b0));
    send_item(make_item(CmdEffect, 2, 15, 0, 2, 33, 1'b1, 1'b0));
    send_item(make_item(CmdTick, 0, 0, 0, 0, 0, 1'b1, 1'b0));
    send_item(make_item(CmdEffect, 3, 15, 0, 2, 40, 1'b0, 1'b0));
    // zero-length effect leaves its priority behind without blocking
    send_item(make_item(CmdEffect, 15, 15, 0, 0, 127, 1'b1, 1'b0));
    send_item(make_item(CmdEffect, 4, 0, 255, 255, 1, 1'b1, 1'b0));
    send_item(make_item(CmdEffect, 5, 0, 0, 1, 100, 1'b1, 1'b0));
    send_item(make_item(CmdTick, 0, 0, 0, 0, 0, 1'b1, 1'b0));
    send_item(make_item(CmdSetActive, 0, 0, 0, 0, 0, 1'b1, 1'b0));
    send_item(make_item(CmdTick, 0, 0, 0, 0, 0, 1'b1, 1'b1));
    send_item(make_item(CmdSetActive, 0, 0, 0, 0, 0, 1'b1, 1'b1));
  endtask

  task automatic test_random_traffic(int unsigned count);
    repeat (count) send_item(random_item($urandom_range(0, 9) == 0));
  endtask

  // Back-to-back items on both sides
  task automatic test_back_to_back(int unsigned count);
    gaps_on = 1'b0;
    test_random_traffic(count);
    gaps_on = 1'b1;
  endtask

  // Hold the result side off so the block fills and stalls its input
  task automatic test_backpressure();
    gaps_on        = 1'b0;
    rx_hold_cycles = 40;
    test_random_traffic(30);
    gaps_on = 1'b1;
  endtask

  // Result side: random stalls, compare each result with the oldest prediction
  initial begin : result_sink
    result_t     want;
    result_t     got;
    int unsigned stall;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = gaps_on ? $urandom_range(0, 8) : 0;
      if (rx_hold_cycles != 0) begin
        stall          = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      got = out_if.data;
      if (pending_results.size() == 0) begin
        $error("result item with nothing pending: %h", got);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.start_shot_voice !== want.start_shot_voice) begin
          $error("start_shot_voice: expected %0d, got %0d",
                 want.start_shot_voice, got.start_shot_voice);
          mismatches++;
        end
        if (got.start_effect_voice !== want.start_effect_voice) begin
          $error("start_effect_voice: expected %0d, got %0d",
                 want.start_effect_voice, got.start_effect_voice);
          mismatches++;
        end
        if (got.start_volume !== want.start_volume) begin
          $error("start_volume: expected %0d, got %0d", want.start_volume, got.start_volume);
          mismatches++;
        end
        if (got.stop_shot_voice !== want.stop_shot_voice) begin
          $error("stop_shot_voice: expected %0d, got %0d",
                 want.stop_shot_voice, got.stop_shot_voice);
          mismatches++;
        end
        if (got.stop_effect_voice !== want.stop_effect_voice) begin
          $error("stop_effect_voice: expected %0d, got %0d",
                 want.stop_effect_voice, got.stop_effect_voice);
          mismatches++;
        end
      end
    end
  end

  // Abort a hung run
  initial begin : watchdog
    #4_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // Reset, then run the tests in turn
  initial begin : main_seq
    in_if.valid    <= 1'b0;
    in_if.data     <= '0;
    rst_ni          = 1'b0;
    mismatches      = 0;
    gaps_on         = 1'b1;
    rx_hold_cycles  = 0;
    arb_active      = 1'b0;
    clear_counters();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    wait_idle();
    test_random_traffic(450);
    // sender pauses until everything is back
    wait_idle();
    test_back_to_back(120);
    test_backpressure();
    test_random_traffic(230);

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
